// ----- hw/rtl/gtr_pkg.sv -----
// shared types, codes and the vertex order table of the gouraud triangle rasterizer
`default_nettype none

package gtr_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOUR_BITS = 8;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_END    = 2'd2,
    KIND_NEXT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_PIXEL  = 2'd0,
    ST_DONE   = 2'd1,
    ST_REJECT = 2'd2,
    ST_SETUP  = 2'd3
  } status_t;

  // bottom, middle and top store index for each y compare code
  localparam logic [1:0] ORDER_TABLE [8][3] = '{
    '{2'd0, 2'd0, 2'd0},
    '{2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd0, 2'd2, 2'd1},
    '{2'd2, 2'd0, 2'd1},
    '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd0, 2'd0}
  };

endpackage

`default_nettype wire

// ----- hw/rtl/gtr_if.sv -----
// request and result channels of the gouraud triangle rasterizer
`default_nettype none

interface gtr_cmd_if #(
  parameter int COORD_BITS = gtr_pkg::COORD_BITS_DEF
) ();
  logic                             valid;
  logic                             ready;
  gtr_pkg::kind_t                   kind;
  logic [COORD_BITS-1:0]            vx;
  logic [COORD_BITS-1:0]            vy;
  logic [gtr_pkg::COLOUR_BITS-1:0]  vred;
  logic [gtr_pkg::COLOUR_BITS-1:0]  vgreen;
  logic [gtr_pkg::COLOUR_BITS-1:0]  vblue;

  modport source (output valid, kind, vx, vy, vred, vgreen, vblue, input ready);
  modport sink (input valid, kind, vx, vy, vred, vgreen, vblue, output ready);
endinterface

interface gtr_res_if #(
  parameter int COORD_BITS = gtr_pkg::COORD_BITS_DEF
) ();
  logic                             valid;
  logic                             ready;
  gtr_pkg::status_t                 status;
  logic [COORD_BITS-1:0]            px;
  logic [COORD_BITS-1:0]            py;
  logic [gtr_pkg::COLOUR_BITS-1:0]  pred;
  logic [gtr_pkg::COLOUR_BITS-1:0]  pgreen;
  logic [gtr_pkg::COLOUR_BITS-1:0]  pblue;
  logic                             last;

  modport source (output valid, status, px, py, pred, pgreen, pblue, last, input ready);
  modport sink (input valid, status, px, py, pred, pgreen, pblue, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gouraud_triangle_rasterizer_unit.sv -----
// gouraud triangle rasterizer: vertex store, sequencer, shared multiplier and divider
//
// A triangle is given as a begin request, three vertex requests and an end request;
// each next request then returns one shaded pixel (or reports that none are left).
// Begin and vertex requests give no result. All arithmetic runs
// through one registered multiplier and one radix-2 restoring divider of
// NB = COORD_BITS + 11 steps under a small sequencer, and the block takes no new
// request until the current one is finished. A pixel inside a row takes three
// colour interpolations. A pixel that closes a row also walks the edges and
// loads the next span: 6 more interpolations per row, plus an edge setup where
// the middle vertex is reached. An end request sorts the vertices, finds the
// orientation, sets up both edges and loads the first span.
`default_nettype none

module gouraud_triangle_rasterizer_unit #(
  parameter int COORD_BITS = gtr_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gtr_cmd_if.sink        cmd,
  gtr_res_if.source      res
);

  localparam int C    = COORD_BITS;
  localparam int W    = C + 3;
  localparam int M    = (W > 9) ? W : 9;
  localparam int P    = 2 * M;
  localparam int NB   = W + 8;
  localparam int CNTW = $clog2(NB + 1);
  localparam int CB   = gtr_pkg::COLOUR_BITS;

  typedef struct packed {
    logic [C-1:0]          x;
    logic [C-1:0]          y;
    logic [2:0][CB-1:0]    c;
  } vtx_t;

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_RDY   = 23'd1 << 1,
    S_SORT  = 23'd1 << 2,
    S_RDV   = 23'd1 << 3,
    S_CRA   = 23'd1 << 4,
    S_CRB   = 23'd1 << 5,
    S_CRC   = 23'd1 << 6,
    S_SET2  = 23'd1 << 7,
    S_SET3  = 23'd1 << 8,
    S_EINIT = 23'd1 << 9,
    S_EDIV  = 23'd1 << 10,
    S_EMUL  = 23'd1 << 11,
    S_EINC  = 23'd1 << 12,
    S_SPAN  = 23'd1 << 13,
    S_SPANW = 23'd1 << 14,
    S_PIX   = 23'd1 << 15,
    S_PIXW  = 23'd1 << 16,
    S_LERP  = 23'd1 << 17,
    S_LMUL  = 23'd1 << 18,
    S_LDIV  = 23'd1 << 19,
    S_ADV   = 23'd1 << 20,
    S_ADVSP = 23'd1 << 21,
    S_EMIT  = 23'd1 << 22
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  function automatic logic signed [W-1:0] sx(input logic [C-1:0] v);
    return signed'(W'(v));
  endfunction

  // control
  state_t                   state;
  state_t                   e_ret;
  state_t                   l_ret;
  phase_t                   phase;
  logic [1:0]               vcount;
  logic [1:0]               sk;
  logic [1:0]               sp_k;
  logic                     es;
  gtr_pkg::status_t         pend;

  // vertex store and sorted copies
  vtx_t                     vmem [3];
  vtx_t                     rd_q;
  logic [1:0]               rd_addr;
  logic [C-1:0]             y0, y1, y2;
  logic [1:0]               o_b, o_m, o_t;
  vtx_t                     vb, vm, vt;
  logic                     lim;

  // edge walkers and span
  logic signed [W-1:0]      ex [2];
  logic signed [W-1:0]      eerr [2];
  logic signed [W-1:0]      estep [2];
  logic signed [W-1:0]      einc [2];
  logic signed [W-1:0]      endy [2];
  logic signed [W-1:0]      e_dx;
  logic [C:0]               row_y;
  logic signed [W-1:0]      span_x;
  logic signed [W-1:0]      ends0, ends1;
  logic [CB-1:0]            col_l [3];
  logic [CB-1:0]            col_r [3];

  // interpolation context
  logic [CB-1:0]            l_c0, l_c1, l_res;
  logic signed [W-1:0]      l_x0, l_x1, l_x;
  logic                     l_neg;

  // shared multiplier and divider
  logic signed [M-1:0]      mul_a, mul_b;
  logic signed [P-1:0]      mul_q;
  logic signed [P-1:0]      prod1;
  logic [NB-1:0]            dv_n;
  logic [W-1:0]             dv_r;
  logic [W-1:0]             dv_d;
  logic [CNTW-1:0]          dv_cnt;
  logic [W:0]               dv_t;
  logic                     dv_ge;
  logic [W:0]               dv_sub;

  // pixel and result registers
  logic [C-1:0]             pix_x, pix_y;
  logic [CB-1:0]            pc [3];
  logic                     o_valid;
  gtr_pkg::status_t         o_status;
  logic [C-1:0]             o_px, o_py;
  logic [CB-1:0]            o_r, o_g, o_b_col;
  logic                     o_last;

  // combinational helpers
  logic [2:0]               flag;
  vtx_t                     lo, hi;
  logic                     mid_edge;
  logic signed [W-1:0]      dx, dy, dx_mag, dy_neg;
  logic signed [W-1:0]      d_a, d_b;
  logic signed [8:0]        cdiff;
  logic signed [P:0]        cross_sum;
  logic                     cross_pos;
  logic signed [W-1:0]      adv_x [2];
  logic signed [W-1:0]      adv_e [2];
  logic signed [W-1:0]      sum_x [2];
  logic signed [W-1:0]      sum_e [2];
  logic signed [W-1:0]      l_den;
  logic [W-1:0]             l_den_mag;
  logic signed [P-1:0]      mul_neg;
  logic signed [NB:0]       qs;
  logic signed [NB+1:0]     lv;
  logic [CB-1:0]            lerp_val;
  logic signed [W-1:0]      step_val;
  logic [C:0]               row_nx;
  logic                     span_empty;

  assign cmd.ready  = (state == S_IDLE);
  assign res.valid  = o_valid;
  assign res.status = o_status;
  assign res.px     = o_px;
  assign res.py     = o_py;
  assign res.pred   = o_r;
  assign res.pgreen = o_g;
  assign res.pblue  = o_b_col;
  assign res.last   = o_last;

  assign flag = {y0 < y1, y1 < y2, y2 < y0};
  assign mid_edge = ~lim;
  assign row_nx = row_y + 1'b1;
  assign span_empty = (phase != PH_ACTIVE) || (span_x >= ends1);

  always_comb begin
    rd_addr = 2'd0;
    if (state == S_RDY) begin
      rd_addr = (sk == 2'd3) ? 2'd0 : sk;
    end else if (state == S_RDV) begin
      case (sk)
        2'd0:    rd_addr = o_b;
        2'd1:    rd_addr = o_m;
        2'd2:    rd_addr = o_t;
        default: rd_addr = o_b;
      endcase
    end
  end

  // endpoints of the edge selected by es at the current row
  always_comb begin
    if (es != mid_edge) begin
      lo = vb;
      hi = vt;
    end else if (row_y < {1'b0, vm.y}) begin
      lo = vb;
      hi = vm;
    end else begin
      lo = vm;
      hi = vt;
    end
    dx = sx(hi.x) - sx(lo.x);
    dy = sx(hi.y) - sx(lo.y);
    dx_mag = dx[W-1] ? -dx : dx;
    dy_neg = -dy;
  end

  always_comb begin
    d_a = '0;
    d_b = '0;
    cdiff = $signed({1'b0, l_c1}) - $signed({1'b0, l_c0});
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CRA: begin
        d_a = sx(vb.y) - sx(vt.y);
        d_b = sx(vm.x) - sx(vb.x);
        mul_a = M'(d_a);
        mul_b = M'(d_b);
      end
      S_CRB: begin
        d_a = sx(vt.x) - sx(vb.x);
        d_b = sx(vm.y) - sx(vb.y);
        mul_a = M'(d_a);
        mul_b = M'(d_b);
      end
      S_EMUL: begin
        mul_a = M'(endy[es]);
        mul_b = M'(estep[es]);
      end
      S_LERP: begin
        d_a = l_x - l_x0;
        mul_a = M'(d_a);
        mul_b = M'(cdiff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cross_sum = (P+1)'(prod1) + (P+1)'(mul_q);
  assign cross_pos = !cross_sum[P] && (cross_sum != '0);

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      sum_x[s] = ex[s] + estep[s];
      sum_e[s] = eerr[s] + einc[s];
      if (!sum_e[s][W-1] && (sum_e[s] != '0)) begin
        adv_x[s] = sum_x[s] + W'(1);
        adv_e[s] = sum_e[s] + endy[s];
      end else begin
        adv_x[s] = sum_x[s];
        adv_e[s] = sum_e[s];
      end
    end
  end

  // divider step, the floor and clamp of an interpolation and the edge step
  always_comb begin
    dv_t   = {dv_r, dv_n[NB-1]};
    dv_ge  = dv_t >= {1'b0, dv_d};
    dv_sub = dv_t - {1'b0, dv_d};
    l_den  = l_x1 - l_x0;
    l_den_mag = l_den[W-1] ? W'(-l_den) : W'(l_den);
    mul_neg = -mul_q;
    if (l_neg) begin
      qs = -$signed({1'b0, dv_n}) - $signed({{NB{1'b0}}, dv_r != '0});
    end else begin
      qs = $signed({1'b0, dv_n});
    end
    lv = (NB+2)'(qs) + $signed((NB+2)'(l_c0));
    if (lv[NB+1]) begin
      lerp_val = '0;
    end else if (|lv[NB:CB]) begin
      lerp_val = '1;
    end else begin
      lerp_val = lv[CB-1:0];
    end
    if (e_dx[W-1]) begin
      step_val = -signed'(W'(dv_n)) - W'(1);
    end else begin
      step_val = signed'(W'(dv_n));
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready && (cmd.kind == gtr_pkg::KIND_VERTEX) && (vcount != 2'd3)) begin
      vmem[vcount] <= '{x: cmd.vx, y: cmd.vy, c: {cmd.vblue, cmd.vgreen, cmd.vred}};
    end
    rd_q <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_IDLE;
      vcount  <= '0;
      dv_cnt  <= '0;
      o_valid <= 1'b0;
    end else begin
      if (res.ready) begin
        o_valid <= 1'b0;
      end
      if (dv_cnt != '0) begin
        dv_r   <= dv_ge ? dv_sub[W-1:0] : dv_t[W-1:0];
        dv_n   <= {dv_n[NB-2:0], dv_ge};
        dv_cnt <= dv_cnt - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            case (cmd.kind)
              gtr_pkg::KIND_BEGIN: begin
                vcount <= '0;
                phase  <= PH_IDLE;
              end
              gtr_pkg::KIND_VERTEX: begin
                if (vcount != 2'd3) begin
                  vcount <= vcount + 1'b1;
                end
              end
              gtr_pkg::KIND_END: begin
                sk    <= '0;
                state <= S_RDY;
              end
              gtr_pkg::KIND_NEXT: begin
                if (span_empty) begin
                  pend  <= gtr_pkg::ST_DONE;
                  state <= S_EMIT;
                end else begin
                  pix_x <= span_x[C-1:0];
                  pix_y <= row_y[C-1:0];
                  sp_k  <= '0;
                  pend  <= gtr_pkg::ST_PIXEL;
                  state <= S_PIX;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RDY: begin
          case (sk)
            2'd1:    y0 <= rd_q.y;
            2'd2:    y1 <= rd_q.y;
            2'd3:    y2 <= rd_q.y;
            default: y0 <= y0;
          endcase
          sk <= sk + 1'b1;
          if (sk == 2'd3) begin
            state <= S_SORT;
          end
        end
        S_SORT: begin
          if (flag inside {3'b000, 3'b111}) begin
            phase <= PH_IDLE;
            pend  <= gtr_pkg::ST_REJECT;
            state <= S_EMIT;
          end else begin
            o_b   <= gtr_pkg::ORDER_TABLE[flag][0];
            o_m   <= gtr_pkg::ORDER_TABLE[flag][1];
            o_t   <= gtr_pkg::ORDER_TABLE[flag][2];
            sk    <= '0;
            state <= S_RDV;
          end
        end
        S_RDV: begin
          case (sk)
            2'd1:    vb <= rd_q;
            2'd2:    vm <= rd_q;
            2'd3:    vt <= rd_q;
            default: vb <= vb;
          endcase
          sk <= sk + 1'b1;
          if (sk == 2'd3) begin
            state <= S_CRA;
          end
        end
        S_CRA: begin
          row_y <= {1'b0, vb.y};
          state <= S_CRB;
        end
        S_CRB: begin
          prod1 <= mul_q;
          state <= S_CRC;
        end
        S_CRC: begin
          lim   <= cross_pos;
          es    <= 1'b0;
          e_ret <= S_SET2;
          state <= S_EINIT;
        end
        S_SET2: begin
          es    <= 1'b1;
          e_ret <= S_SET3;
          state <= S_EINIT;
        end
        S_SET3: begin
          es    <= 1'b0;
          sp_k  <= '0;
          phase <= PH_ACTIVE;
          pend  <= gtr_pkg::ST_SETUP;
          state <= S_SPAN;
        end
        S_EINIT: begin
          ex[es]   <= sx(lo.x);
          eerr[es] <= '0;
          e_dx     <= dx;
          if (dy == '0) begin
            estep[es] <= '0;
            einc[es]  <= '0;
            endy[es]  <= '0;
            state     <= e_ret;
          end else begin
            endy[es] <= dy_neg;
            dv_n     <= NB'(dx_mag);
            dv_r     <= '0;
            dv_d     <= W'(dy);
            dv_cnt   <= CNTW'(NB);
            state    <= S_EDIV;
          end
        end
        S_EDIV: begin
          if (dv_cnt == '0) begin
            estep[es] <= step_val;
            state     <= S_EMUL;
          end
        end
        S_EMUL: begin
          state <= S_EINC;
        end
        S_EINC: begin
          einc[es] <= W'(mul_q) + e_dx;
          state    <= e_ret;
        end
        S_SPAN: begin
          if (sp_k == 2'd3) begin
            if (es) begin
              ends0  <= ex[0];
              ends1  <= ex[1];
              span_x <= ex[0];
              state  <= S_ADV;
            end else begin
              es   <= 1'b1;
              sp_k <= '0;
            end
          end else begin
            l_c0  <= lo.c[sp_k];
            l_x0  <= sx(lo.x);
            l_c1  <= hi.c[sp_k];
            l_x1  <= sx(hi.x);
            l_x   <= ex[es];
            l_ret <= S_SPANW;
            state <= S_LERP;
          end
        end
        S_SPANW: begin
          if (es) begin
            col_r[sp_k] <= l_res;
          end else begin
            col_l[sp_k] <= l_res;
          end
          sp_k  <= sp_k + 1'b1;
          state <= S_SPAN;
        end
        S_PIX: begin
          if (sp_k == 2'd3) begin
            span_x <= span_x + W'(1);
            state  <= S_ADV;
          end else begin
            l_c0  <= col_r[sp_k];
            l_x0  <= ends1;
            l_c1  <= col_l[sp_k];
            l_x1  <= ends0;
            l_x   <= span_x;
            l_ret <= S_PIXW;
            state <= S_LERP;
          end
        end
        S_PIXW: begin
          pc[sp_k] <= l_res;
          sp_k     <= sp_k + 1'b1;
          state    <= S_PIX;
        end
        S_LERP: begin
          if (l_x1 == l_x0) begin
            l_res <= l_c0;
            state <= l_ret;
          end else begin
            state <= S_LMUL;
          end
        end
        S_LMUL: begin
          dv_n   <= mul_q[P-1] ? NB'(mul_neg) : NB'(mul_q);
          dv_r   <= '0;
          dv_d   <= l_den_mag;
          dv_cnt <= CNTW'(NB);
          l_neg  <= mul_q[P-1] ^ l_den[W-1];
          state  <= S_LDIV;
        end
        S_LDIV: begin
          if (dv_cnt == '0) begin
            l_res <= lerp_val;
            state <= l_ret;
          end
        end
        S_ADV: begin
          if (span_empty || (phase != PH_ACTIVE)) begin
            if (phase == PH_ACTIVE) begin
              ex[0]   <= adv_x[0];
              ex[1]   <= adv_x[1];
              eerr[0] <= adv_e[0];
              eerr[1] <= adv_e[1];
              row_y   <= row_nx;
              if (row_nx > {1'b0, vt.y}) begin
                phase <= PH_DONE;
                state <= S_EMIT;
              end else if (row_nx == {1'b0, vm.y}) begin
                es    <= mid_edge;
                e_ret <= S_ADVSP;
                state <= S_EINIT;
              end else begin
                state <= S_ADVSP;
              end
            end else begin
              state <= S_EMIT;
            end
          end else begin
            state <= S_EMIT;
          end
        end
        S_ADVSP: begin
          es    <= 1'b0;
          sp_k  <= '0;
          state <= S_SPAN;
        end
        S_EMIT: begin
          if (!o_valid || res.ready) begin
            o_valid  <= 1'b1;
            o_status <= pend;
            if (pend == gtr_pkg::ST_PIXEL) begin
              o_px    <= pix_x;
              o_py    <= pix_y;
              o_r     <= pc[0];
              o_g     <= pc[1];
              o_b_col <= pc[2];
              o_last  <= (phase == PH_DONE);
            end else begin
              o_px    <= '0;
              o_py    <= '0;
              o_r     <= '0;
              o_g     <= '0;
              o_b_col <= '0;
              o_last  <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider is never restarted while it is still stepping
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LMUL) || ((state == S_EINIT) && (dy != '0))) |-> (dv_cnt == '0))
    else $error("divider started while busy");

  // no request is taken while the divider is still working
  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (dv_cnt == '0))
    else $error("request port ready with divider busy");

  // a pixel result is only produced for a set-up triangle
  a_pixel_needs_triangle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && (pend == gtr_pkg::ST_PIXEL)) |-> (phase != PH_IDLE))
    else $error("pixel emitted without an active triangle");

  // a triangle only finishes drawing on its way to a result
  a_done_from_pixel: assert property (@(posedge clk) disable iff (rst)
    ((phase != PH_DONE) && (state == S_ADV)) |=> ((phase != PH_DONE) || (state == S_EMIT)))
    else $error("triangle finished outside the pixel path");

endmodule

`default_nettype wire
